// File: design/ppeds_pkg.sv
// Package for the point to polygon edge distance block: widths, types and states.
// No dependencies.
package ppeds_pkg;
    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int SQ_BITS    = 2 * DIFF_BITS;
    localparam int SUM_BITS   = SQ_BITS + 1;
    localparam int DOT_BITS   = SQ_BITS + 1;
    localparam int DIST_BITS  = 50;
    localparam int DIV_BITS   = SUM_BITS;
    localparam int CNT_BITS   = $clog2(2 * DIV_BITS + 1);
    localparam int LO_BITS    = SUM_BITS / 2;
    localparam int HI_BITS    = SUM_BITS - LO_BITS;
    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef logic signed [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord px;
        t_coord py;
        logic   open_poly;
        logic   emit;
    } t_edge;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_PROD, ST_SUM, ST_SQ, ST_NUM, ST_DIV, ST_TAKE, ST_EMIT
    } t_state;
endpackage

// File: design/ppeds_if.sv
// Valid/ready channel interfaces for the vertex input and the distance output.
// Depends on ppeds_pkg.
interface ppeds_in_if;
    import ppeds_pkg::*;
    logic   valid;
    logic   ready;
    t_coord vertex_x;
    t_coord vertex_y;
    t_coord test_x;
    t_coord test_y;
    logic   last_vertex;
    modport source(output valid, vertex_x, vertex_y, test_x, test_y, last_vertex,
                   input ready);
    modport sink(input valid, vertex_x, vertex_y, test_x, test_y, last_vertex,
                 output ready);
endinterface

interface ppeds_out_if;
    import ppeds_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [DIST_BITS-1:0] min_dist_sq;
    modport source(output valid, min_dist_sq, input ready);
    modport sink(input valid, min_dist_sq, output ready);
endinterface

// File: design/ppeds_front.sv
// Front end: takes vertex beats, tracks first/previous vertex, queues edge jobs.
// Depends on ppeds_pkg and ppeds_if.
module ppeds_front
    import ppeds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppeds_in_if.sink    i_vtx,
    input  logic        i_q_ready,
    output logic        o_q_valid,
    output t_edge       o_q_edge
);
    logic   r_mid;
    logic   r_pend;
    t_coord r_fx, r_fy, r_vx, r_vy, r_px, r_py;
    logic   r_qv;
    t_edge  r_q;
    logic   q_free, acc;
    t_coord ax, ay;

    assign q_free      = !r_qv || i_q_ready;
    assign i_vtx.ready = q_free && !r_pend;
    assign acc         = i_vtx.valid && i_vtx.ready;
    assign o_q_valid   = r_qv;
    assign o_q_edge    = r_q;
    assign ax = r_mid ? r_vx : i_vtx.vertex_x;
    assign ay = r_mid ? r_vy : i_vtx.vertex_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid  <= 1'b0;
            r_pend <= 1'b0;
            r_qv   <= 1'b0;
        end else begin
            r_qv <= (r_pend && q_free) || acc || (r_qv && !q_free);
            if (r_pend && q_free) begin
                r_pend <= 1'b0;
                r_q    <= '{ax: r_vx, ay: r_vy, bx: r_fx, by: r_fy, px: r_px, py: r_py,
                            open_poly: 1'b0, emit: 1'b1};
            end else if (acc) begin
                r_q  <= '{ax: ax, ay: ay, bx: i_vtx.vertex_x, by: i_vtx.vertex_y,
                          px: r_mid ? r_px : i_vtx.test_x,
                          py: r_mid ? r_py : i_vtx.test_y,
                          open_poly: !r_mid, emit: 1'b0};
                if (!r_mid) begin
                    r_fx <= i_vtx.vertex_x;
                    r_fy <= i_vtx.vertex_y;
                    r_px <= i_vtx.test_x;
                    r_py <= i_vtx.test_y;
                end
                r_vx   <= i_vtx.vertex_x;
                r_vy   <= i_vtx.vertex_y;
                r_mid  <= !i_vtx.last_vertex;
                r_pend <= i_vtx.last_vertex;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_acc_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !acc) else $error("beat taken while closing edge pending");
    a_pend_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && q_free) |=> !r_pend) else $error("closing edge stuck");
    a_last_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_vtx.last_vertex) |=> (r_pend && !r_mid))
        else $error("last vertex did not schedule close");
`endif
endmodule

// File: design/ppeds_back.sv
// Back end: squared segment distance per edge, shared restoring divider, running minimum.
// Depends on ppeds_pkg and ppeds_if.
module ppeds_back
    import ppeds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_edge       i_q_edge,
    output logic        o_q_ready,
    ppeds_out_if.source o_res
);
    t_state r_st, n_st;
    t_edge  r_e;
    logic signed [DIFF_BITS-1:0] r_apx, r_apy, r_abx, r_aby, r_bpx, r_bpy;
    logic [SQ_BITS-1:0]          r_p0, r_p1, r_l0, r_l1, r_b0, r_b1;
    logic signed [SQ_BITS-1:0]   r_d0, r_d1;
    logic [SUM_BITS-1:0]         r_ap2, r_len, r_bp2, r_rem, r_q;
    logic signed [DOT_BITS-1:0]  r_dot;
    logic [2*HI_BITS-1:0]        r_hh;
    logic [HI_BITS+LO_BITS-1:0]  r_hl;
    logic [2*LO_BITS-1:0]        r_ll;
    logic [2*DIV_BITS-1:0]       r_sq;
    logic [CNT_BITS-1:0]         r_cnt;
    logic [DIST_BITS-1:0]        r_best;
    logic                        r_ov;
    logic [DIST_BITS-1:0]        r_out;
    logic [SUM_BITS:0]           trial;
    logic [SUM_BITS-1:0]         dotu;
    logic [SUM_BITS-1:0]         cand;
    logic [DIST_BITS-1:0]        cand_sat;
    logic                        out_free;

    assign out_free     = !r_ov || o_res.ready;
    assign o_res.valid  = r_ov;
    assign o_res.min_dist_sq = r_out;
    assign dotu  = SUM_BITS'(r_dot);
    assign trial = {r_rem, r_sq[2*DIV_BITS-1]};

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: if (i_q_valid) n_st = ST_DIFF;
            ST_DIFF: n_st = ST_PROD;
            ST_PROD: n_st = ST_SUM;
            ST_SUM:  n_st = ST_SQ;
            ST_SQ:   n_st = (r_len == '0 || r_dot <= 0 || dotu >= r_len) ? ST_TAKE : ST_NUM;
            ST_NUM:  n_st = ST_DIV;
            ST_DIV:  if (r_cnt == CNT_BITS'(2*DIV_BITS-1)) n_st = ST_TAKE;
            ST_TAKE: n_st = r_e.emit ? ST_EMIT : ST_IDLE;
            ST_EMIT: if (out_free) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_q_ready = (r_st == ST_IDLE);
        if (r_len == '0 || r_dot <= 0) cand = r_ap2;
        else if (dotu >= r_len)        cand = r_bp2;
        else                           cand = r_ap2 - r_q;
        cand_sat = (cand > SUM_BITS'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(cand);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= (r_st == ST_EMIT && out_free) || (r_ov && !o_res.ready);
            if (r_st == ST_EMIT && out_free) begin
                r_out <= r_best;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_st)
            ST_IDLE: if (i_q_valid) begin
                r_e <= i_q_edge;
                if (i_q_edge.open_poly) r_best <= DIST_MAX;
            end
            ST_DIFF: begin
                r_apx <= DIFF_BITS'(r_e.px) - DIFF_BITS'(r_e.ax);
                r_apy <= DIFF_BITS'(r_e.py) - DIFF_BITS'(r_e.ay);
                r_abx <= DIFF_BITS'(r_e.bx) - DIFF_BITS'(r_e.ax);
                r_aby <= DIFF_BITS'(r_e.by) - DIFF_BITS'(r_e.ay);
                r_bpx <= DIFF_BITS'(r_e.px) - DIFF_BITS'(r_e.bx);
                r_bpy <= DIFF_BITS'(r_e.py) - DIFF_BITS'(r_e.by);
            end
            ST_PROD: begin
                r_p0 <= SQ_BITS'(r_apx * r_apx);
                r_p1 <= SQ_BITS'(r_apy * r_apy);
                r_l0 <= SQ_BITS'(r_abx * r_abx);
                r_l1 <= SQ_BITS'(r_aby * r_aby);
                r_b0 <= SQ_BITS'(r_bpx * r_bpx);
                r_b1 <= SQ_BITS'(r_bpy * r_bpy);
                r_d0 <= r_apx * r_abx;
                r_d1 <= r_apy * r_aby;
            end
            ST_SUM: begin
                r_ap2 <= SUM_BITS'(r_p0) + SUM_BITS'(r_p1);
                r_len <= SUM_BITS'(r_l0) + SUM_BITS'(r_l1);
                r_bp2 <= SUM_BITS'(r_b0) + SUM_BITS'(r_b1);
                r_dot <= DOT_BITS'(r_d0) + DOT_BITS'(r_d1);
            end
            ST_SQ: begin
                r_hh <= dotu[SUM_BITS-1:LO_BITS] * dotu[SUM_BITS-1:LO_BITS];
                r_hl <= dotu[SUM_BITS-1:LO_BITS] * dotu[LO_BITS-1:0];
                r_ll <= dotu[LO_BITS-1:0] * dotu[LO_BITS-1:0];
            end
            ST_NUM: begin
                r_sq  <= ((2*DIV_BITS)'(r_hh) << (2*LO_BITS))
                       + ((2*DIV_BITS)'(r_hl) << (LO_BITS + 1))
                       + (2*DIV_BITS)'(r_ll);
                r_cnt <= '0;
                r_rem <= '0;
                r_q   <= '0;
            end
            ST_DIV: begin
                // shift in one numerator bit per step
                r_cnt <= r_cnt + 1'b1;
                r_sq  <= r_sq << 1;
                if (trial >= {1'b0, r_len}) begin
                    r_rem <= SUM_BITS'(trial - {1'b0, r_len});
                    r_q   <= {r_q[SUM_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= SUM_BITS'(trial);
                    r_q   <= {r_q[SUM_BITS-2:0], 1'b0};
                end
            end
            ST_TAKE: begin
                if (cand_sat < r_best) r_best <= cand_sat;
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready) |=> $stable(r_out)) else $error("result changed");
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_ready |-> (r_st == ST_IDLE)) else $error("ready outside idle");
    a_emit_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_EMIT && out_free) |=> r_ov) else $error("result lost");
`endif
endmodule

// File: design/point_polygon_edge_distance_sq.sv
// Point to polygon boundary squared distance: top level joining front end and back end.
// Depends on ppeds_pkg, ppeds_if, ppeds_front and ppeds_back.
// Feed one vertex per beat with the test point on the first; a beat with last_vertex
// set closes the polygon and yields one min_dist_sq beat (unsigned integer). Each edge
// runs through the back end, with the one-bit-per-cycle restoring divider computing
// dot^2/|AB|^2; edges that clamp to an endpoint or have zero length skip the
// divider. Every vertex queues the edge from the previous vertex (zero-length for the
// first), and the last vertex also queues the closing edge, which emits the result.
module point_polygon_edge_distance_sq
    import ppeds_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppeds_in_if.sink     i_vtx,
    ppeds_out_if.source  o_res
);
    logic  q_valid, q_ready;
    t_edge q_edge;

    ppeds_front u_front (.i_clk, .i_rst_n, .i_vtx, .i_q_ready(q_ready),
                         .o_q_valid(q_valid), .o_q_edge(q_edge));
    ppeds_back  u_back  (.i_clk, .i_rst_n, .i_q_valid(q_valid), .i_q_edge(q_edge),
                         .o_q_ready(q_ready), .o_res);
endmodule

// File: test/tb_ppeds_if.sv
// Testbench copy note: the channel interfaces live in design/ppeds_if.sv.
// This file holds the small timing constants shared by the testbench top.
// No dependencies.
`timescale 1ns / 100ps
package tb_ppeds_cfg_pkg;
    localparam int CLK_HALF = 2;
    localparam int RST_CYCLES = 7;
endpackage

// File: test/tb_point_polygon_edge_distance_sq.sv
// Testbench for point_polygon_edge_distance_sq: streams polygons, predicts the minimum
// squared edge distance per polygon and checks each result beat in order.
// Depends on ppeds_pkg, ppeds_if, the block itself and tb_ppeds_cfg_pkg.
`timescale 1ns / 100ps
module tb_point_polygon_edge_distance_sq;
    import ppeds_pkg::*;
    import tb_ppeds_cfg_pkg::*;

    localparam logic [49:0] DMAX = {50{1'b1}};

    class dist_board;
        logic signed [63:0] fx, fy, pvx, pvy, ptx, pty;
        logic [49:0]        best;
        bit                 open_poly;
        logic [49:0]        pending[$];
        int                 errors;
        int                 polys;

        function logic [49:0] edge_sq(logic signed [63:0] ax, logic signed [63:0] ay,
                                      logic signed [63:0] bx, logic signed [63:0] by);
            logic signed [63:0] apx, apy, abx, aby, bpx, bpy, dot;
            logic [63:0]        ap2, len, r;
            logic [127:0]       num;
            apx = ptx - ax; apy = pty - ay;
            abx = bx - ax;  aby = by - ay;
            bpx = ptx - bx; bpy = pty - by;
            ap2 = apx * apx + apy * apy;
            len = abx * abx + aby * aby;
            dot = apx * abx + apy * aby;
            if (len == 0 || dot <= 0) begin
                r = ap2;
            end else if (64'(dot) >= len) begin
                r = bpx * bpx + bpy * bpy;
            end else begin
                num = 128'(dot) * 128'(dot);
                r = ap2 - 64'(num / 128'(len));
            end
            return (r > 64'(DMAX)) ? DMAX : r[49:0];
        endfunction

        function void note_vertex(t_coord vx, t_coord vy, t_coord tx, t_coord ty, logic lst);
            logic [49:0] d;
            if (!open_poly) begin
                ptx = tx; pty = ty; fx = vx; fy = vy;
                best = DMAX; open_poly = 1;
            end else begin
                d = edge_sq(pvx, pvy, vx, vy);
                if (d < best) best = d;
            end
            pvx = vx; pvy = vy;
            if (lst) begin
                d = edge_sq(vx, vy, fx, fy);
                if (d < best) best = d;
                open_poly = 0;
                pending.push_back(best);
            end
        endfunction

        function void check_result(logic [49:0] got);
            logic [49:0] exp_d;
            if (pending.size() == 0) begin
                $error("min_dist_sq: unexpected beat, actual %0d", got);
                errors++;
                return;
            end
            exp_d = pending.pop_front();
            polys++;
            if (got !== exp_d) begin
                $error("min_dist_sq: expected %0d actual %0d", exp_d, got);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    ppeds_in_if  vtx_if();
    ppeds_out_if res_if();

    point_polygon_edge_distance_sq i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vtx(vtx_if.sink), .o_res(res_if.source)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    dist_board board = new();
    int send_idle = 34;
    int recv_idle = 66;
    bit hold_off = 0;
    int sent_vertices = 0;

    initial begin
        vtx_if.valid = 0;
        vtx_if.vertex_x = 0; vtx_if.vertex_y = 0;
        vtx_if.test_x = 0; vtx_if.test_y = 0;
        vtx_if.last_vertex = 0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && vtx_if.valid && vtx_if.ready) begin
            board.note_vertex(vtx_if.vertex_x, vtx_if.vertex_y, vtx_if.test_x,
                              vtx_if.test_y, vtx_if.last_vertex);
        end
        if (i_rst_n && res_if.valid && res_if.ready) begin
            board.check_result(res_if.min_dist_sq);
        end
    end

    always @(negedge i_clk) begin
        res_if.ready <= i_rst_n && !hold_off && ($urandom_range(99) >= recv_idle);
    end

    function automatic t_coord rnd_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'($urandom_range(2047) - 1024);
            default: return t_coord'($urandom_range(511) - 256);
        endcase
    endfunction

    task automatic send_vertex(t_coord vx, t_coord vy, t_coord tx, t_coord ty, logic lst);
        while ($urandom_range(99) < send_idle) begin
            vtx_if.valid <= 0;
            @(negedge i_clk);
        end
        vtx_if.valid <= 1;
        vtx_if.vertex_x <= vx; vtx_if.vertex_y <= vy;
        vtx_if.test_x <= tx; vtx_if.test_y <= ty;
        vtx_if.last_vertex <= lst;
        @(posedge i_clk);
        while (!vtx_if.ready) @(posedge i_clk);
        @(negedge i_clk);
        sent_vertices++;
    endtask

    task automatic send_polygon(int n, int mode);
        t_coord tx, ty;
        tx = rnd_coord(mode); ty = rnd_coord(mode);
        for (int k = 0; k < n; k++) begin
            send_vertex(rnd_coord(mode), rnd_coord(mode),
                        (k == 0) ? tx : rnd_coord(0), (k == 0) ? ty : rnd_coord(0),
                        k == n - 1);
        end
    endtask

    task automatic random_phase(int count);
        int start;
        start = sent_vertices;
        while (sent_vertices - start < count) begin
            send_polygon($urandom_range(6, 1), $urandom_range(2));
        end
    endtask

    localparam t_coord CMAX = 24'sh7FFFFF;
    localparam t_coord CMIN = 24'sh800000;

    initial begin
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        // directed: single vertex, extremes, degenerate and clamped edges
        send_vertex(CMAX, CMAX, CMIN, CMIN, 1);
        send_vertex(CMIN, CMIN, CMAX, CMAX, 1);
        send_vertex(0, 0, 0, 0, 1);
        send_vertex(CMIN, CMAX, CMAX, CMIN, 0);
        send_vertex(CMAX, CMIN, 0, 0, 0);
        send_vertex(CMIN, CMIN, 24'sh555555, 24'sh2AAAAA, 1);
        send_vertex(0, 0, 256, 100, 0);
        send_vertex(0, 0, 0, 0, 0);
        send_vertex(512, 0, 0, 0, 1);
        send_vertex(0, 0, -300, 50, 0);
        send_vertex(256, 0, CMAX, CMIN, 1);
        send_vertex(0, 0, 700, 5, 0);
        send_vertex(256, 256, 1, 1, 1);
        send_vertex(CMAX, 0, 0, CMAX, 0);
        send_vertex(0, CMAX, 0, 0, 0);
        send_vertex(CMIN, CMIN, 0, 0, 1);
        random_phase(400);
        send_idle = 66; recv_idle = 34;
        random_phase(400);
        send_idle = 0; recv_idle = 0;
        random_phase(150);
        fork
            begin
                hold_off = 1;
                repeat (3000) @(negedge i_clk);
                hold_off = 0;
            end
            random_phase(40);
        join
        random_phase(200);
        vtx_if.valid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        $display("Checked %0d polygons from %0d vertex beats with stalls and backpressure.",
                 board.polys, sent_vertices);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb_point_polygon_edge_distance_sq OK");
        end else begin
            $display("tb_point_polygon_edge_distance_sq NOT OK");
        end
        $finish;
    end

    initial begin
        #(40_000_000);
        $display("tb_point_polygon_edge_distance_sq NOT OK");
        $finish;
    end
endmodule
